>>> rtl/core/adcss_pkg.sv
`default_nettype none

package adcss_pkg;

  // Register map, byte offsets within the 4 KiB window.
  localparam logic [11:0] OFF_START     = 12'h000;
  localparam logic [11:0] OFF_STATUS    = 12'h010;
  localparam logic [11:0] OFF_MASK      = 12'h014;
  localparam logic [11:0] OFF_CONTROL   = 12'h030;
  localparam logic [11:0] OFF_SEQ       = 12'h034;
  localparam logic [11:0] OFF_LASTCH    = 12'h03C;
  localparam logic [11:0] OFF_PLAIN_END = 12'h040;
  localparam logic [11:0] OFF_SAMPLES   = 12'h050;

  localparam int DONE_POS     = 1;
  localparam int START_EN_POS = 7;
  localparam int ONE_SHOT_POS = 0;
  localparam int CH_LSB       = 12;

  localparam logic [31:0] MASK_RESET = 32'h0000_000F;
  localparam logic [11:0] RAW_RESET  = 12'd3698;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [11:0] byte_offset;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/adcss_ctrl.sv
`default_nettype none

module adcss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output adcss_pkg::cmd_t    cmd
);
  import adcss_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    rsp_valid_next = rsp_valid;
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_BUSY;
        end
      end
      ST_BUSY: begin
        // The access runs only once the result register is free to take its word.
        if (!rsp_valid || rsp_ready) begin
          cmd.execute    = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_busy_after_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !req_ready)
    else $error("request accepted while an access was pending");

  a_execute_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> (!rsp_valid || rsp_ready))
    else $error("result overwritten before it was taken");

  a_execute_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> rsp_valid)
    else $error("executed access produced no result");

  a_commands_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute in the same cycle");

endmodule

`default_nettype wire

>>> rtl/core/adcss_datapath.sv
`default_nettype none

module adcss_datapath #(
  parameter int CHANNEL_COUNT = 9
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire adcss_pkg::cmd_t cmd,
  input  wire adcss_pkg::req_t req,
  input  wire logic            cfg_we,
  input  wire logic [11:0]     cfg_data,
  output adcss_pkg::rsp_t      rsp
);
  import adcss_pkg::*;

  localparam int          CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [4:0]  CH_LIMIT = 5'(CHANNEL_COUNT);
  localparam logic [9:0]  K_LIMIT  = 10'(CHANNEL_COUNT);

  req_t        req_q;
  logic [11:0] battery_level_raw;
  logic [31:0] start_source;
  logic        done_pending;
  logic [31:0] interrupt_mask;
  logic [31:0] control_word;
  logic [31:0] sequencer_word;
  logic [3:0]  last_channel;
  logic [11:0] channel_samples [CHANNEL_COUNT];
  logic [31:0] plain_settings [16];

  logic [31:0] start_source_next;
  logic        done_pending_next;
  logic [31:0] interrupt_mask_next;
  logic [31:0] control_word_next;
  logic [31:0] sequencer_word_next;
  logic [3:0]  last_channel_next;
  logic        sample_we;
  logic        plain_we;

  logic [11:0] off;
  logic [11:0] sample_rel;
  logic [9:0]  sample_k;
  logic        sample_hit;
  logic [3:0]  conv_ch;
  logic        conv_ch_ok;
  logic [31:0] rd_value;
  logic        is_write;

  // Bits 1:0 of the offset are dropped, so any byte address hits its word.
  assign off        = {req_q.byte_offset[11:2], 2'b00};
  assign is_write   = (req_q.mode == MODE_WRITE);
  assign sample_rel = off - OFF_SAMPLES;
  assign sample_k   = sample_rel[11:2];
  assign sample_hit = (off >= OFF_SAMPLES) && (sample_k < K_LIMIT);
  assign conv_ch    = sequencer_word[CH_LSB +: 4];
  assign conv_ch_ok = ({1'b0, conv_ch} < CH_LIMIT);

  always_comb begin
    start_source_next   = start_source;
    done_pending_next   = done_pending;
    interrupt_mask_next = interrupt_mask;
    control_word_next   = control_word;
    sequencer_word_next = sequencer_word;
    last_channel_next   = last_channel;
    sample_we           = 1'b0;
    plain_we            = 1'b0;
    if (is_write) begin
      case (off)
        OFF_START:  start_source_next = req_q.write_data;
        OFF_STATUS: begin
          if (req_q.write_data[DONE_POS]) begin
            done_pending_next = 1'b0;
          end
        end
        OFF_MASK:   interrupt_mask_next = req_q.write_data;
        OFF_CONTROL: begin
          control_word_next = req_q.write_data;
          // Level trigger: every qualifying control write converts.
          if (req_q.write_data[ONE_SHOT_POS] && start_source[START_EN_POS] && conv_ch_ok) begin
            sample_we         = 1'b1;
            last_channel_next = conv_ch;
            done_pending_next = 1'b1;
          end
        end
        OFF_SEQ:    sequencer_word_next = req_q.write_data;
        OFF_LASTCH: begin
        end
        default: begin
          if (off < OFF_PLAIN_END) begin
            plain_we = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    rd_value = '0;
    if (!is_write) begin
      case (off)
        OFF_START:   rd_value = start_source;
        OFF_STATUS:  rd_value = done_pending ? (32'd1 << DONE_POS) : 32'd0;
        OFF_MASK:    rd_value = interrupt_mask;
        OFF_CONTROL: rd_value = control_word;
        OFF_SEQ:     rd_value = sequencer_word;
        OFF_LASTCH:  rd_value = {28'd0, last_channel};
        default: begin
          if (sample_hit) begin
            rd_value = {20'd0, channel_samples[sample_k[CH_IDX_W-1:0]]};
          end else if (off < OFF_PLAIN_END) begin
            rd_value = plain_settings[off[5:2]];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.execute) begin
      rsp.read_data <= rd_value;
      rsp.irq_level <= done_pending_next && !interrupt_mask_next[DONE_POS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_level_raw <= RAW_RESET;
      start_source      <= '0;
      done_pending      <= 1'b0;
      interrupt_mask    <= MASK_RESET;
      control_word      <= '0;
      sequencer_word    <= '0;
      last_channel      <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        channel_samples[i] <= '0;
      end
      for (int i = 0; i < 16; i++) begin
        plain_settings[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        battery_level_raw <= cfg_data;
      end
      if (cmd.execute) begin
        start_source   <= start_source_next;
        done_pending   <= done_pending_next;
        interrupt_mask <= interrupt_mask_next;
        control_word   <= control_word_next;
        sequencer_word <= sequencer_word_next;
        last_channel   <= last_channel_next;
        if (sample_we) begin
          channel_samples[conv_ch[CH_IDX_W-1:0]] <= battery_level_raw;
        end
        if (plain_we) begin
          plain_settings[off[5:2]] <= req_q.write_data;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/adc_single_shot_register_block_top.sv
`default_nettype none
// A request word is registered when accepted and its result word when the controller
// executes it, once the result register is free. Accesses alternate between capture
// and execute; the next request is taken while a result still waits downstream.
// Reset (rst, synchronous, active high) sets the mask to 0xF, the raw value to 3698,
// clears all but the request and result words; requests are taken in the cycle after.
module adc_single_shot_register_block_top #(
  parameter int CHANNEL_COUNT = 9
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire adcss_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output adcss_pkg::rsp_t      rsp,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [11:0]     cfg_data
);
  import adcss_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  adcss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  adcss_datapath #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
